FILE: rtl/gn2d_pkg.sv
package gn2d_pkg;

	// fraction bits of the coordinates and of all internal fixed-point values
	localparam int FRAC_BITS = 16;
	localparam int ONE_FX    = 1 << FRAC_BITS;
	localparam int HALF_FX   = 1 << (FRAC_BITS - 1);

	// fade output, 0 .. ONE_FX
	localparam int FADE_W = FRAC_BITS + 1;

	localparam int NOISE_W = 17;

	localparam logic [7:0] PERM_ROM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};

endpackage

FILE: rtl/gradient_noise_2d.sv
// 2D gradient noise, one sample per input word.
// Throughput: one word per cycle; each stage holds under back-pressure and
// empty stages fill while the output waits.
// Reset: arst_n clears the stage valid bits only; the data path is not reset.
module gradient_noise_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] x_coord, [63:32] y_coord
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [16:0] noise_value, rest zero
);

	localparam int F    = gn2d_pkg::FRAC_BITS;
	localparam int NS   = 8;
	localparam int UW   = gn2d_pkg::FADE_W;
	localparam int GW   = F + 3;        // corner dot product, -2 .. 2
	localparam int DW   = F + 4;        // corner difference
	localparam int RW   = F + 4;        // row blend
	localparam int RDW  = F + 5;        // row difference
	localparam int P1W  = UW + 1 + DW;
	localparam int P2W  = UW + 1 + RDW;
	localparam int RESW = F + 7;
	localparam int SH_R = (F > 15) ? F - 15 : 1;
	localparam int SH_L = (F < 15) ? 15 - F : 0;

	function automatic logic signed [GW-1:0] grad(
		input logic [2:0]        h,
		input logic signed [F:0] dx,
		input logic signed [F:0] dy
	);
		logic signed [GW-1:0] a;
		logic signed [GW-1:0] b;
		a = h[2] ? GW'(dy) : GW'(dx);
		b = h[2] ? GW'(dx) : GW'(dy);
		if (h[0])
			a = -a;
		if (h[1])
			b = -b;
		return a + b;
	endfunction

	// handshake: a stage loads when it is empty or its successor loads
	logic [NS:1]   vld_s;
	logic [NS+1:1] en;

	always_comb begin
		en[NS+1] = m_axis_tready;
		for (int k = NS; k >= 1; k--)
			en[k] = !vld_s[k] || en[k+1];
	end

	assign s_axis_tready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1])
				vld_s[1] <= s_axis_tvalid;
			for (int k = 2; k <= NS; k++)
				if (en[k])
					vld_s[k] <= vld_s[k-1];
		end
	end

	// input split
	logic [F-1:0] fx_in, fy_in;
	logic [7:0]   cx_in, cy_in;

	assign fx_in = s_axis_tdata[F-1:0];
	assign fy_in = s_axis_tdata[32+F-1:32];
	assign cx_in = s_axis_tdata[F+7:F];
	assign cy_in = s_axis_tdata[32+F+7:32+F];

	logic [UW-1:0] u_fade, v_fade;

	gn2d_fade u_fade_x (
		.clk (clk),
		.en  (en[4:1]),
		.t   (fx_in),
		.f   (u_fade)
	);

	gn2d_fade u_fade_y (
		.clk (clk),
		.en  (en[4:1]),
		.t   (fy_in),
		.f   (v_fade)
	);

	// stage registers
	logic [F-1:0]          fx_s1, fy_s1, fx_s2, fy_s2;
	logic [7:0]            pa_s1, pb_s1, cy_s1;
	logic [2:0]            haa_s2, hba_s2, hab_s2, hbb_s2;
	logic signed [GW-1:0]  g00_s3, g10_s3, g01_s3, g11_s3;
	logic signed [GW-1:0]  g00_s4, g01_s4, g00_s5, g01_s5;
	logic signed [DW-1:0]  d0_s4, d1_s4;
	logic signed [P1W-1:0] prod0_s5, prod1_s5;
	logic [UW-1:0]         v_s5, v_s6;
	logic signed [RW-1:0]  row0_s6, row0_s7;
	logic signed [RDW-1:0] rdiff_s6;
	logic signed [P2W-1:0] prod2_s7;
	logic [gn2d_pkg::NOISE_W-1:0] noise_s8;

	// combinational per stage
	logic [7:0]            ha, hb, ha1, hb1;
	logic signed [F:0]     dx0, dx1, dy0, dy1;
	logic signed [P1W-1:0] q0, q1;
	logic signed [RW-1:0]  row0, row1;
	logic signed [P2W-1:0] q2;
	logic signed [RESW-1:0] res, sv;
	logic [F+1:0]          sc;
	logic [31:0]           r;

	always_comb begin
		ha  = pa_s1 + cy_s1;
		hb  = pb_s1 + cy_s1;
		ha1 = ha + 8'd1;
		hb1 = hb + 8'd1;

		dx0 = $signed({1'b0, fx_s2});
		dx1 = $signed({1'b1, fx_s2});   // fx - 1.0
		dy0 = $signed({1'b0, fy_s2});
		dy1 = $signed({1'b1, fy_s2});

		q0   = prod0_s5 + P1W'(gn2d_pkg::HALF_FX);
		q1   = prod1_s5 + P1W'(gn2d_pkg::HALF_FX);
		row0 = RW'(g00_s5) + RW'($signed(q0[P1W-1:F]));
		row1 = RW'(g01_s5) + RW'($signed(q1[P1W-1:F]));

		q2  = prod2_s7 + P2W'(gn2d_pkg::HALF_FX);
		res = RESW'(row0_s7) + RESW'($signed(q2[P2W-1:F]));
		sv  = res + RESW'(gn2d_pkg::ONE_FX);
		if (sv < 0)
			sc = '0;
		else if (sv > RESW'(2 * gn2d_pkg::ONE_FX))
			sc = (F+2)'(2 * gn2d_pkg::ONE_FX);
		else
			sc = sv[F+1:0];

		if (F > 15)
			r = (32'(sc) + (32'd1 << (SH_R - 1))) >> SH_R;
		else
			r = 32'(sc) << SH_L;
		if (r > 32'd65536)
			r = 32'd65536;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			fx_s1 <= fx_in;
			fy_s1 <= fy_in;
			cy_s1 <= cy_in;
			pa_s1 <= gn2d_pkg::PERM_ROM[cx_in];
			pb_s1 <= gn2d_pkg::PERM_ROM[cx_in + 8'd1];
		end
		if (en[2]) begin
			fx_s2  <= fx_s1;
			fy_s2  <= fy_s1;
			haa_s2 <= gn2d_pkg::PERM_ROM[ha][2:0];
			hba_s2 <= gn2d_pkg::PERM_ROM[hb][2:0];
			hab_s2 <= gn2d_pkg::PERM_ROM[ha1][2:0];
			hbb_s2 <= gn2d_pkg::PERM_ROM[hb1][2:0];
		end
		if (en[3]) begin
			g00_s3 <= grad(haa_s2, dx0, dy0);
			g10_s3 <= grad(hba_s2, dx1, dy0);
			g01_s3 <= grad(hab_s2, dx0, dy1);
			g11_s3 <= grad(hbb_s2, dx1, dy1);
		end
		if (en[4]) begin
			g00_s4 <= g00_s3;
			g01_s4 <= g01_s3;
			d0_s4  <= DW'(g10_s3) - DW'(g00_s3);
			d1_s4  <= DW'(g11_s3) - DW'(g01_s3);
		end
		if (en[5]) begin
			prod0_s5 <= P1W'($signed({1'b0, u_fade})) * P1W'(d0_s4);
			prod1_s5 <= P1W'($signed({1'b0, u_fade})) * P1W'(d1_s4);
			g00_s5   <= g00_s4;
			g01_s5   <= g01_s4;
			v_s5     <= v_fade;
		end
		if (en[6]) begin
			row0_s6  <= row0;
			rdiff_s6 <= RDW'(row1) - RDW'(row0);
			v_s6     <= v_s5;
		end
		if (en[7]) begin
			prod2_s7 <= P2W'($signed({1'b0, v_s6})) * P2W'(rdiff_s6);
			row0_s7  <= row0_s6;
		end
		if (en[8])
			noise_s8 <= r[gn2d_pkg::NOISE_W-1:0];
	end

	assign m_axis_tvalid = vld_s[NS];
	assign m_axis_tdata  = {(24 - gn2d_pkg::NOISE_W)'(0), noise_s8};

`ifndef NO_ASSERTIONS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with output stage empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[1])
		else $error("accepted word missing from first stage");

	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[16:0] <= 17'd65536)
		else $error("noise value above one");

	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS-1] && en[NS] |=> vld_s[NS])
		else $error("word lost entering output stage");
`endif

endmodule

FILE: rtl/gn2d_fade.sv
// quintic fade 6t^5 - 15t^4 + 10t^3, four register stages
module gn2d_fade (
	input  logic                              clk,
	input  logic [3:0]                        en,  // stage loads, first stage in bit 0
	input  logic [gn2d_pkg::FRAC_BITS-1:0]    t,
	output logic [gn2d_pkg::FADE_W-1:0]       f
);

	localparam int F    = gn2d_pkg::FRAC_BITS;
	localparam int PW   = 2 * F + 4;
	localparam int P2W  = F + 4;

	logic [F-1:0]     t_s1, t_s2;
	logic [2*F-1:0]   tt_s1;
	logic [F:0]       t2_s2, t3_s3;
	logic [P2W-1:0]   p2_s2, p2_s3;
	logic [F:0]       f_s4;

	logic [2*F:0]     t2_sum;
	logic [PW-1:0]    poly;
	logic [PW:0]      p2_sum;
	logic [2*F+1:0]   t3_sum;
	logic [2*F+5:0]   f_sum;
	logic [F+5:0]     f_raw;

	always_comb begin
		t2_sum = {1'b0, tt_s1} + (2*F+1)'(gn2d_pkg::HALF_FX);
		// 10 - 15t + 6t^2, scaled by one squared; never negative
		poly   = (PW'(10) << (2 * F)) + PW'(tt_s1) * PW'(6)
			- ((PW'(t_s1) * PW'(15)) << F);
		p2_sum = {1'b0, poly} + (PW+1)'(gn2d_pkg::HALF_FX);
		t3_sum = (2*F+2)'(t2_s2) * (2*F+2)'(t_s2) + (2*F+2)'(gn2d_pkg::HALF_FX);
		f_sum  = (2*F+6)'(t3_s3) * (2*F+6)'(p2_s3) + (2*F+6)'(gn2d_pkg::HALF_FX);
		f_raw  = f_sum[2*F+5:F];
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s1  <= t;
			tt_s1 <= (2*F)'(t) * (2*F)'(t);
		end
		if (en[1]) begin
			t_s2  <= t_s1;
			t2_s2 <= t2_sum[2*F:F];
			p2_s2 <= p2_sum[F+P2W-1:F];
		end
		if (en[2]) begin
			t3_s3 <= t3_sum[2*F:F];
			p2_s3 <= p2_s2;
		end
		if (en[3]) begin
			if (f_raw > (F+6)'(gn2d_pkg::ONE_FX))
				f_s4 <= (F+1)'(gn2d_pkg::ONE_FX);
			else
				f_s4 <= f_raw[F:0];
		end
	end

	assign f = f_s4;

endmodule
